// ===== rtl/core/rpcv_pkg.sv =====
// Shared types, RAM addresses, operation codes and the sine table builder
// for the cube vertex projector. Depends on nothing.
`timescale 1ns / 1ps

package rpcv_pkg;

   localparam int RAM_DEPTH = 32;
   localparam int ADDR_W = $clog2(RAM_DEPTH);

   localparam logic [ADDR_W-1:0] A_CX   = 5'd0;
   localparam logic [ADDR_W-1:0] A_SX   = 5'd1;
   localparam logic [ADDR_W-1:0] A_CY   = 5'd2;
   localparam logic [ADDR_W-1:0] A_SY   = 5'd3;
   localparam logic [ADDR_W-1:0] A_CZ   = 5'd4;
   localparam logic [ADDR_W-1:0] A_SZ   = 5'd5;
   localparam logic [ADDR_W-1:0] A_SYCZ = 5'd6;
   localparam logic [ADDR_W-1:0] A_SYSZ = 5'd7;
   localparam logic [ADDR_W-1:0] A_M0   = 5'd8;
   localparam logic [ADDR_W-1:0] A_M1   = 5'd9;
   localparam logic [ADDR_W-1:0] A_M2   = 5'd10;
   localparam logic [ADDR_W-1:0] A_M3   = 5'd11;
   localparam logic [ADDR_W-1:0] A_M4   = 5'd12;
   localparam logic [ADDR_W-1:0] A_M5   = 5'd13;
   localparam logic [ADDR_W-1:0] A_M6   = 5'd14;
   localparam logic [ADDR_W-1:0] A_M7   = 5'd15;
   localparam logic [ADDR_W-1:0] A_M8   = 5'd16;
   localparam logic [ADDR_W-1:0] A_C0   = 5'd17;
   localparam logic [ADDR_W-1:0] A_C1   = 5'd18;
   localparam logic [ADDR_W-1:0] A_C2   = 5'd19;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_DIV180 = PI_Q60 / 64'd180;
   localparam logic [63:0] PI_MOD180 = PI_Q60 % 64'd180;

   typedef enum logic [3:0] {
      OP_TRIG,
      OP_MUL,
      OP_MULADD,
      OP_MULSUB,
      OP_NEG,
      OP_MOV,
      OP_ADD,
      OP_SUB,
      OP_ADDK,
      OP_DIV,
      OP_MULINV,
      OP_SCALEX,
      OP_SCALEY
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] ra;
      logic [ADDR_W-1:0] rb;
      logic [ADDR_W-1:0] wa;
      logic              capture;
      logic              ex_en;
      logic              wb_en;
      logic              div_start;
      logic              emit;
      logic [2:0]        vtx;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_full;
   } sts_type;

   typedef logic [31:0] sin_rom_type [0:90];

   // Restoring long division, used only while the sine table is built.
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sin_rom_type build_sin_rom(int frac);
      sin_rom_type rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] dd;
      logic [63:0] dv;
      logic [127:0] p;
      for (int d = 0; d <= 90; d++) begin
         dd = 64'(d);
         x = PI_DIV180 * dd + udiv64(PI_MOD180 * dd, 64'd180);
         p = 128'(x) * 128'(x);
         x2 = p[123:60];
         term = x;
         sum = x;
         for (int n = 1; n <= 16; n++) begin
            p = 128'(term) * 128'(x2);
            dv = 64'((2 * n) * (2 * n + 1));
            term = udiv64(p[123:60], dv);
            if (n[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         sum = sum + (64'd1 << (59 - frac));
         dv = sum >> (60 - frac);
         rom[d] = dv[31:0];
      end
      return rom;
   endfunction

endpackage

// ===== rtl/core/rpcv_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps

module rpcv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/core/rpcv_datapath.sv =====
// Datapath: operand RAM, sine table, shared multiplier, bit-serial divider,
// projection clamp and the result word register. Uses rpcv_pkg and rpcv_ram.
`timescale 1ns / 1ps

module rpcv_datapath
   import rpcv_pkg::*;
#(
   parameter int FRAC_BITS = 24,
   parameter int DISPLAY_WIDTH = 96,
   parameter int DISPLAY_HEIGHT = 64,
   localparam int XW = $clog2(DISPLAY_WIDTH),
   localparam int YW = $clog2(DISPLAY_HEIGHT)
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic [8:0]    rot_x_deg,
   input  logic [8:0]    rot_y_deg,
   input  logic [8:0]    rot_z_deg,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [2:0]    rsp_vertex_index,
   output logic [XW-1:0] rsp_screen_x,
   output logic [YW-1:0] rsp_screen_y,
   output logic          rsp_last_point
);

   localparam sin_rom_type SIN_ROM = build_sin_rom(FRAC_BITS);
   localparam logic signed [31:0] FOUR = 32'sd4 <<< FRAC_BITS;
   localparam logic signed [31:0] CENTER_Y = 32'(DISPLAY_HEIGHT / 2);
   localparam logic signed [63:0] CX64 = 64'(DISPLAY_WIDTH / 2);
   localparam logic signed [63:0] CY64 = 64'(DISPLAY_HEIGHT / 2);
   localparam logic signed [63:0] XMAX = 64'(DISPLAY_WIDTH - 1);
   localparam logic signed [63:0] YMAX = 64'(DISPLAY_HEIGHT - 1);
   localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
   localparam int CW = $clog2(DIV_STEPS);

   logic [8:0] ang_x_ff;
   logic [8:0] ang_y_ff;
   logic [8:0] ang_z_ff;
   logic signed [31:0] acc_ff;
   logic signed [63:0] product_ff;
   logic signed [31:0] inv_ff;
   logic [XW-1:0] out_x_ff;
   logic [YW-1:0] out_y_ff;

   logic          div_busy_ff;
   logic          div_done_ff;
   logic [CW-1:0] div_cnt_ff;
   logic [31:0]   div_d_ff;
   logic [31:0]   div_rem_ff;
   logic [31:0]   div_q_ff;
   logic          div_neg_ff;
   logic          div_zero_ff;

   logic          rsp_valid_ff;
   logic [2:0]    rsp_vtx_ff;
   logic [XW-1:0] rsp_x_ff;
   logic [YW-1:0] rsp_y_ff;
   logic          rsp_last_ff;

   logic signed [31:0] ram_a;
   logic signed [31:0] ram_b;
   logic               ram_we;
   logic signed [31:0] result;
   logic signed [31:0] opa;
   logic signed [31:0] opb;
   logic signed [63:0] shifted;
   logic signed [31:0] fm;
   logic signed [63:0] scr;
   logic [8:0]         ang;
   logic [8:0]         ang_red;
   logic [9:0]         ang_cos;
   logic [8:0]         ang_q;
   logic [6:0]         rom_idx;
   logic               rom_neg;
   logic signed [31:0] trig;
   logic [32:0]        rem_sh;
   logic [32:0]        rem_sub;
   logic               q_bit;
   logic [31:0]        rem_next;
   logic [31:0]        q_next;
   logic [31:0]        denom_mag;

   rpcv_ram #(
      .WIDTH(32),
      .DEPTH(RAM_DEPTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (ram_we),
      .wr_addr  (cmd.wa),
      .wr_data  (result),
      .rd_addr_a(cmd.ra),
      .rd_addr_b(cmd.rb),
      .rd_data_a(ram_a),
      .rd_data_b(ram_b)
   );

   always_comb begin
      unique case (cmd.wa[2:1])
         2'd0:    ang = ang_x_ff;
         2'd1:    ang = ang_y_ff;
         default: ang = ang_z_ff;
      endcase
      ang_red = (ang >= 9'd360) ? ang - 9'd360 : ang;
      ang_cos = {1'b0, ang_red};
      if (!cmd.wa[0]) begin
         ang_cos = {1'b0, ang_red} + 10'd90;
         if (ang_cos >= 10'd360) begin
            ang_cos = ang_cos - 10'd360;
         end
      end
      ang_q = ang_cos[8:0];
      priority if (ang_q <= 9'd90) begin
         rom_idx = ang_q[6:0];
         rom_neg = 1'b0;
      end else if (ang_q <= 9'd180) begin
         rom_idx = 7'(9'd180 - ang_q);
         rom_neg = 1'b0;
      end else if (ang_q <= 9'd270) begin
         rom_idx = 7'(ang_q - 9'd180);
         rom_neg = 1'b1;
      end else begin
         rom_idx = 7'(9'd360 - ang_q);
         rom_neg = 1'b1;
      end
      trig = rom_neg ? -$signed(SIN_ROM[rom_idx]) : $signed(SIN_ROM[rom_idx]);
   end

   always_comb begin
      opa = (cmd.op == OP_SCALEX || cmd.op == OP_SCALEY) ? acc_ff : ram_a;
      if (cmd.op == OP_MULINV) begin
         opb = inv_ff;
      end else if (cmd.op == OP_SCALEX || cmd.op == OP_SCALEY) begin
         opb = CENTER_Y;
      end else begin
         opb = ram_b;
      end
      shifted = product_ff >>> FRAC_BITS;
      fm = shifted[31:0];
      if (cmd.op == OP_SCALEX) begin
         scr = CX64 + shifted;
      end else begin
         scr = CY64 - shifted;
      end
   end

   always_comb begin
      unique case (cmd.op)
         OP_TRIG:   result = trig;
         OP_MUL:    result = fm;
         OP_MULADD: result = acc_ff + fm;
         OP_MULSUB: result = acc_ff - fm;
         OP_NEG:    result = -ram_a;
         OP_MOV:    result = ram_a;
         OP_ADD:    result = acc_ff + ram_a;
         OP_SUB:    result = acc_ff - ram_a;
         OP_ADDK:   result = acc_ff + FOUR;
         OP_MULINV: result = fm;
         default:   result = acc_ff;
      endcase
      ram_we = cmd.wb_en && (cmd.op == OP_TRIG || cmd.op == OP_MUL
         || cmd.op == OP_MULADD || cmd.op == OP_MULSUB || cmd.op == OP_NEG
         || cmd.op == OP_MOV || cmd.op == OP_ADD || cmd.op == OP_SUB);
   end

   always_comb begin
      denom_mag = acc_ff[31] ? 32'(-acc_ff) : acc_ff;
      rem_sh = {div_rem_ff, (div_cnt_ff == CW'(DIV_STEPS - 1))};
      rem_sub = rem_sh - {1'b0, div_d_ff};
      q_bit = !rem_sub[32];
      rem_next = q_bit ? rem_sub[31:0] : rem_sh[31:0];
      q_next = {div_q_ff[30:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ang_x_ff <= rot_x_deg;
         ang_y_ff <= rot_y_deg;
         ang_z_ff <= rot_z_deg;
      end
      if (cmd.ex_en) begin
         product_ff <= opa * opb;
      end
      if (cmd.wb_en && cmd.op != OP_DIV && cmd.op != OP_SCALEX
         && cmd.op != OP_SCALEY) begin
         acc_ff <= result;
      end
      if (cmd.wb_en && cmd.op == OP_SCALEX) begin
         if (scr < 0) begin
            out_x_ff <= '0;
         end else if (scr > XMAX) begin
            out_x_ff <= XMAX[XW-1:0];
         end else begin
            out_x_ff <= scr[XW-1:0];
         end
      end
      if (cmd.wb_en && cmd.op == OP_SCALEY) begin
         if (scr < 0) begin
            out_y_ff <= '0;
         end else if (scr > YMAX) begin
            out_y_ff <= YMAX[YW-1:0];
         end else begin
            out_y_ff <= scr[YW-1:0];
         end
      end
      if (cmd.div_start) begin
         div_d_ff <= denom_mag;
         div_neg_ff <= acc_ff[31];
         div_zero_ff <= (acc_ff == 0);
         div_rem_ff <= '0;
         div_q_ff <= '0;
      end else if (div_busy_ff) begin
         div_rem_ff <= rem_next;
         div_q_ff <= q_next;
         if (div_cnt_ff == '0) begin
            if (div_zero_ff) begin
               inv_ff <= '0;
            end else if (div_neg_ff) begin
               inv_ff <= -$signed(q_next);
            end else begin
               inv_ff <= $signed(q_next);
            end
         end
      end
      if (cmd.emit) begin
         rsp_vtx_ff <= cmd.vtx;
         rsp_x_ff <= out_x_ff;
         rsp_y_ff <= out_y_ff;
         rsp_last_ff <= (cmd.vtx == 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_done_ff <= 1'b0;
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
            div_cnt_ff <= CW'(DIV_STEPS - 1);
         end else if (div_busy_ff) begin
            if (div_cnt_ff == '0) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end else begin
               div_cnt_ff <= div_cnt_ff - 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.div_done = div_done_ff;
   assign sts.rsp_full = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_vertex_index = rsp_vtx_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;
   assign rsp_last_point = rsp_last_ff;

endmodule

// ===== rtl/core/rpcv_ctrl.sv =====
// Controller: sequences the matrix build and the eight vertex programs
// through the datapath. Uses rpcv_pkg.
`timescale 1ns / 1ps

module rpcv_ctrl
   import rpcv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_EX,
      S_WB,
      S_DIV,
      S_EMIT
   } state_type;

   state_type  state_ff;
   logic [4:0] pc_ff;
   logic       vert_ff;
   logic [2:0] vtx_ff;

   op_type            op;
   logic [ADDR_W-1:0] ra;
   logic [ADDR_W-1:0] rb;
   logic [ADDR_W-1:0] wa;
   logic              px_neg;
   logic              last_op;

   always_comb begin
      op = OP_MOV;
      ra = A_CX;
      rb = A_CX;
      wa = A_CX;
      px_neg = (vtx_ff == 3'd1 || vtx_ff == 3'd2 || vtx_ff == 3'd5 || vtx_ff == 3'd6);
      if (!vert_ff) begin
         unique case (pc_ff)
            5'd0:  begin op = OP_TRIG; wa = A_CX; end
            5'd1:  begin op = OP_TRIG; wa = A_SX; end
            5'd2:  begin op = OP_TRIG; wa = A_CY; end
            5'd3:  begin op = OP_TRIG; wa = A_SY; end
            5'd4:  begin op = OP_TRIG; wa = A_CZ; end
            5'd5:  begin op = OP_TRIG; wa = A_SZ; end
            5'd6:  begin op = OP_MUL; ra = A_SY; rb = A_CZ; wa = A_SYCZ; end
            5'd7:  begin op = OP_MUL; ra = A_SY; rb = A_SZ; wa = A_SYSZ; end
            5'd8:  begin op = OP_MUL; ra = A_CY; rb = A_CZ; wa = A_M0; end
            5'd9:  begin op = OP_MUL; ra = A_CY; rb = A_SZ; wa = A_M1; end
            5'd10: begin op = OP_NEG; ra = A_SY; wa = A_M2; end
            5'd11: begin op = OP_MUL; ra = A_SX; rb = A_SYCZ; wa = A_M3; end
            5'd12: begin op = OP_MULSUB; ra = A_CX; rb = A_SZ; wa = A_M3; end
            5'd13: begin op = OP_MUL; ra = A_SX; rb = A_SYSZ; wa = A_M4; end
            5'd14: begin op = OP_MULADD; ra = A_CX; rb = A_CZ; wa = A_M4; end
            5'd15: begin op = OP_MUL; ra = A_SX; rb = A_CY; wa = A_M5; end
            5'd16: begin op = OP_MUL; ra = A_CX; rb = A_SYCZ; wa = A_M6; end
            5'd17: begin op = OP_MULADD; ra = A_SX; rb = A_SZ; wa = A_M6; end
            5'd18: begin op = OP_MUL; ra = A_CX; rb = A_SYSZ; wa = A_M7; end
            5'd19: begin op = OP_MULSUB; ra = A_SX; rb = A_CZ; wa = A_M7; end
            default: begin op = OP_MUL; ra = A_CX; rb = A_CY; wa = A_M8; end
         endcase
      end else begin
         unique case (pc_ff)
            5'd0:  begin op = px_neg ? OP_NEG : OP_MOV; ra = A_M0; wa = A_C0; end
            5'd1:  begin op = vtx_ff[1] ? OP_SUB : OP_ADD; ra = A_M1; wa = A_C0; end
            5'd2:  begin op = vtx_ff[2] ? OP_SUB : OP_ADD; ra = A_M2; wa = A_C0; end
            5'd3:  begin op = px_neg ? OP_NEG : OP_MOV; ra = A_M3; wa = A_C1; end
            5'd4:  begin op = vtx_ff[1] ? OP_SUB : OP_ADD; ra = A_M4; wa = A_C1; end
            5'd5:  begin op = vtx_ff[2] ? OP_SUB : OP_ADD; ra = A_M5; wa = A_C1; end
            5'd6:  begin op = px_neg ? OP_NEG : OP_MOV; ra = A_M6; wa = A_C2; end
            5'd7:  begin op = vtx_ff[1] ? OP_SUB : OP_ADD; ra = A_M7; wa = A_C2; end
            5'd8:  begin op = vtx_ff[2] ? OP_SUB : OP_ADD; ra = A_M8; wa = A_C2; end
            5'd9:  op = OP_ADDK;
            5'd10: op = OP_DIV;
            5'd11: begin op = OP_MULINV; ra = A_C0; end
            5'd12: op = OP_SCALEX;
            5'd13: begin op = OP_MULINV; ra = A_C1; end
            default: op = OP_SCALEY;
         endcase
      end
      last_op = vert_ff ? (pc_ff == 5'd14) : (pc_ff == 5'd20);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign cmd.op = op;
   assign cmd.ra = ra;
   assign cmd.rb = rb;
   assign cmd.wa = wa;
   assign cmd.capture = req_valid && (state_ff == S_IDLE);
   assign cmd.ex_en = (state_ff == S_EX);
   assign cmd.wb_en = (state_ff == S_WB);
   assign cmd.div_start = (state_ff == S_EX) && (op == OP_DIV);
   assign cmd.emit = (state_ff == S_EMIT) && !sts.rsp_full;
   assign cmd.vtx = vtx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         vert_ff <= 1'b0;
         vtx_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_RD;
                  pc_ff <= '0;
                  vert_ff <= 1'b0;
                  vtx_ff <= '0;
               end
            end
            S_RD: state_ff <= S_EX;
            S_EX: state_ff <= (op == OP_DIV) ? S_DIV : S_WB;
            S_WB, S_DIV: begin
               if (state_ff == S_WB || sts.div_done) begin
                  if (last_op && !vert_ff) begin
                     vert_ff <= 1'b1;
                     pc_ff <= '0;
                     vtx_ff <= '0;
                     state_ff <= S_RD;
                  end else if (last_op) begin
                     state_ff <= S_EMIT;
                  end else begin
                     pc_ff <= pc_ff + 1'b1;
                     state_ff <= S_RD;
                  end
               end
            end
            default: begin
               if (!sts.rsp_full) begin
                  if (vtx_ff == 3'd7) begin
                     state_ff <= S_IDLE;
                  end else begin
                     vtx_ff <= vtx_ff + 1'b1;
                     pc_ff <= '0;
                     state_ff <= S_RD;
                  end
               end
            end
         endcase
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.rsp_full)
      else $error("result word loaded while the output register is occupied");

   a_div_resume: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && sts.div_done) |=> (state_ff == S_RD && pc_ff == 5'd11))
      else $error("sequencer did not resume after the divide");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_RD && pc_ff == 5'd0 && !vert_ff))
      else $error("accepted word did not start the matrix program");

endmodule

// ===== rtl/core/rotate_project_cube_vertices_top.sv =====
// Top level of the rotated cube vertex projector.
// Uses rpcv_pkg, rpcv_ctrl and rpcv_datapath.
`timescale 1ns / 1ps

// One request word carries three angles in degrees and yields eight response
// words, one per cube vertex in vertex order, the eighth flagged as last. Each
// vertex waits on the one bit per cycle divider, and every other operation
// steps through the read, execute and write-back states, using the operand
// RAM and the shared 32 by 32 multiplier. A new request is taken only after
// the previous frame's last word is loaded into the output register.
module rotate_project_cube_vertices_top
   import rpcv_pkg::*;
#(
   parameter int FRAC_BITS = 24,
   parameter int DISPLAY_WIDTH = 96,
   parameter int DISPLAY_HEIGHT = 64,
   localparam int XW = $clog2(DISPLAY_WIDTH),
   localparam int YW = $clog2(DISPLAY_HEIGHT)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [8:0]    req_rot_x_deg,
   input  logic [8:0]    req_rot_y_deg,
   input  logic [8:0]    req_rot_z_deg,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_vertex_index,
   output logic [XW-1:0] rsp_screen_x,
   output logic [YW-1:0] rsp_screen_y,
   output logic          rsp_last_point
);

   cmd_type cmd;
   sts_type sts;

   rpcv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   rpcv_datapath #(
      .FRAC_BITS     (FRAC_BITS),
      .DISPLAY_WIDTH (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .rot_x_deg       (req_rot_x_deg),
      .rot_y_deg       (req_rot_y_deg),
      .rot_z_deg       (req_rot_z_deg),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_vertex_index(rsp_vertex_index),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_last_point  (rsp_last_point)
   );

endmodule
